// ===== src/rlep_pkg.sv =====
// Shared types and constants of the run-length encoder with positions.
`default_nettype none
package rlep_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int POS_BITS       = 32;
  localparam int RUNS_BITS      = 16;
  localparam int CFG_DATA_BITS  = 16;

  // Result queue: room for two results of one item plus slack for a stalled sink.
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [0:0] {
    CFG_MAX_RUNS       = 1'b0,
    CFG_WITH_POSITIONS = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] run_value;
    logic [POS_BITS-1:0]           run_length;
    logic [POS_BITS-1:0]           start_pos;
    logic [POS_BITS-1:0]           end_pos;
    logic                          last_run;
  } out_item_t;

  // Results produced by one item: cnt of them, in order first then second.
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  first;
    out_item_t  second;
  } push_t;

endpackage
`default_nettype wire

// ===== src/rlep_core.sv =====
// Run tracking state and per-item result generation.
`default_nettype none
module rlep_core
  import rlep_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     take,
  input  wire in_item_t                 item,
  input  wire logic [RUNS_BITS-1:0]     max_runs,
  input  wire logic                     with_positions,
  output push_t                         push
);

  localparam logic [POS_BITS-1:0]  POS_MAX  = '1;
  localparam logic [RUNS_BITS-1:0] RUNS_MAX = '1;

  logic signed [SAMPLE_BITS-1:0] current_value;
  logic [POS_BITS-1:0]           run_start;
  logic [POS_BITS-1:0]           position;
  logic [RUNS_BITS-1:0]          runs_emitted;
  logic                          in_sequence;
  logic                          limit_hit;

  logic signed [SAMPLE_BITS-1:0] current_value_next;
  logic [POS_BITS-1:0]           run_start_next;
  logic [POS_BITS-1:0]           position_next;
  logic [RUNS_BITS-1:0]          runs_emitted_next;
  logic                          limit_hit_next;

  logic                          emit_change;
  logic                          emit_close;
  logic                          restart;
  logic [RUNS_BITS-1:0]          runs_mid;
  logic                          limit_mid;
  out_item_t                     res_change;
  out_item_t                     res_close;
  logic [POS_BITS-1:0]           change_end;

  always_comb begin
    restart       = !in_sequence;
    position_next = restart ? POS_BITS'(1)
                  : ((position != POS_MAX) ? position + POS_BITS'(1) : position);

    emit_change = in_sequence && !limit_hit && (item.sample != current_value);

    if (restart) begin
      runs_mid = '0;
    end else if (emit_change && runs_emitted != RUNS_MAX) begin
      runs_mid = runs_emitted + RUNS_BITS'(1);
    end else begin
      runs_mid = runs_emitted;
    end

    limit_mid = !restart &&
                (limit_hit || (emit_change && max_runs != '0 && runs_mid >= max_runs));

    current_value_next = (restart || emit_change) ? item.sample : current_value;
    run_start_next     = (restart || emit_change) ? position_next : run_start;

    // Close the open run on the last sample unless the limit is already reached.
    emit_close = item.last_sample && !limit_mid &&
                 !(max_runs != '0 && runs_mid >= max_runs);

    runs_emitted_next = (emit_close && runs_mid != RUNS_MAX) ? runs_mid + RUNS_BITS'(1)
                                                             : runs_mid;
    limit_hit_next    = limit_mid;

    change_end            = position_next - POS_BITS'(1);
    res_change.run_value  = current_value;
    res_change.run_length = position_next - run_start;
    res_change.start_pos  = with_positions ? run_start : '0;
    res_change.end_pos    = with_positions ? change_end : '0;
    res_change.last_run   = limit_mid;

    res_close.run_value   = current_value_next;
    res_close.run_length  = position_next - run_start_next + POS_BITS'(1);
    res_close.start_pos   = with_positions ? run_start_next : '0;
    res_close.end_pos     = with_positions ? position_next : '0;
    res_close.last_run    = 1'b1;

    push.second = res_close;
    if (!take) begin
      push.cnt   = 2'd0;
      push.first = res_change;
    end else if (emit_change) begin
      push.cnt   = emit_close ? 2'd2 : 2'd1;
      push.first = res_change;
    end else begin
      push.cnt   = emit_close ? 2'd1 : 2'd0;
      push.first = res_close;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_value <= '0;
      run_start     <= '0;
      position      <= '0;
      runs_emitted  <= '0;
      in_sequence   <= 1'b0;
      limit_hit     <= 1'b0;
    end else if (take) begin
      current_value <= current_value_next;
      run_start     <= run_start_next;
      position      <= position_next;
      runs_emitted  <= runs_emitted_next;
      in_sequence   <= !item.last_sample;
      limit_hit     <= limit_hit_next;
    end
  end

  a_no_push_when_idle: assert property (@(posedge clk) disable iff (rst)
    !take |-> push.cnt == 2'd0)
    else $error("results pushed without an item");

  a_last_ends_sequence: assert property (@(posedge clk) disable iff (rst)
    (take && item.last_sample) |=> !in_sequence)
    else $error("sequence still open after its last sample");

  a_first_sample_position: assert property (@(posedge clk) disable iff (rst)
    (take && !in_sequence) |=> (position == POS_BITS'(1) && run_start == POS_BITS'(1)))
    else $error("new sequence did not start at position one");

endmodule
`default_nettype wire

// ===== src/rlep_out_fifo.sv =====
// Result queue: up to two results in a cycle, one out if unstalled.
`default_nettype none
module rlep_out_fifo
  import rlep_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire push_t     push,
  output logic           space_ok,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  out_item_t                mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr;
  logic [FIFO_PTR_BITS-1:0] rd_ptr;
  logic [FIFO_CNT_BITS-1:0] count;
  logic [FIFO_CNT_BITS-1:0] count_next;
  logic                     pop;

  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;
  // Leave room for the two results one item may produce.
  assign space_ok  = (count <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
  assign count_next = count + FIFO_CNT_BITS'(push.cnt) - FIFO_CNT_BITS'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr + FIFO_PTR_BITS'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_BITS'(push.cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_BITS'(1);
      end
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.cnt != 2'd0 |-> count <= FIFO_CNT_BITS'(FIFO_DEPTH - 2))
    else $error("push without room in result queue");

  a_push_cnt_legal: assert property (@(posedge clk) disable iff (rst)
    push.cnt != 2'd3)
    else $error("more than two results from one item");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && push.cnt == 2'd0) |=> count == $past(count) - FIFO_CNT_BITS'(1))
    else $error("queue count did not drop on delivery");

endmodule
`default_nettype wire

// ===== src/run_length_encoder_with_positions.sv =====
// Top level: configuration registers, input register, run core and result queue.
// An item passes the input register, then the run core, and its results are registered
// in the result queue.
// Throughput: one item per cycle while the result queue has room; an item that closes
// two runs delivers them one after the other through the queue's single read port.
// Reset (rst, synchronous): no open sequence, queue empty, max_runs 0, with_positions 1.
`default_nettype none
module run_length_encoder_with_positions
  import rlep_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_wr_en,
  input  wire cfg_index_t               cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire in_item_t                 in_item,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output out_item_t                     out_item
);

  logic [RUNS_BITS-1:0] max_runs;
  logic                 with_positions;
  in_item_t             item;
  logic                 item_valid;
  logic                 take;
  logic                 space_ok;
  push_t                push;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_runs       <= '0;
      with_positions <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MAX_RUNS:       max_runs       <= cfg_data[RUNS_BITS-1:0];
        CFG_WITH_POSITIONS: with_positions <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign take     = item_valid && space_ok;
  assign in_stall = item_valid && !space_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  // Payload register: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_item;
    end
  end

  rlep_core u_core (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .item           (item),
    .max_runs       (max_runs),
    .with_positions (with_positions),
    .push           (push)
  );

  rlep_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> item_valid)
    else $error("input stalled with no item held");

  a_held_item_kept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !take) |=> (item_valid && $stable(item)))
    else $error("held item lost before processing");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (item_valid && item == $past(in_item)))
    else $error("accepted item not captured");

endmodule
`default_nettype wire
